### hw/rtl/packed_field_array_autowiden_assert.svh
// ----------------------------------------------------------------------------
// packed_field_array_autowiden_assert
// Assertion macros for the packed field array RTL.
// ----------------------------------------------------------------------------
`ifndef PACKED_FIELD_ARRAY_AUTOWIDEN_ASSERT_SVH
`define PACKED_FIELD_ARRAY_AUTOWIDEN_ASSERT_SVH

// condition holds at every edge out of reset
`define PFA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define PFA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### hw/rtl/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Types, constants and width tables for the packed field array.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int WORD_BITS   = 64;
  localparam int MAX_ENTRIES = 4096;
  localparam int CNT_W       = 13;
  localparam int IDX_W       = 12;
  localparam int VAL_W       = 31;
  localparam int WID_W       = 5;
  localparam int OFF_W       = 6;
  localparam int PER_W       = 7;
  localparam int RCP_W       = 24;
  localparam logic [WID_W-1:0] RESET_WIDTH = 5'd4;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_REPACK = 2'd2,
    OP_LOAD   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECIDE,
    ST_RP_RD,
    ST_RP_EXT,
    ST_CP,
    ST_ADR1,
    ST_ADR2,
    ST_ADR3,
    ST_EXEC,
    ST_DONE
  } state_t;

  // entries per 64-bit word at a given width
  function automatic logic [PER_W-1:0] per_of(logic [WID_W-1:0] w);
    logic [PER_W-1:0] p;
    p = '0;
    case (w) inside
      5'd1:            p = 7'd64;
      5'd2:            p = 7'd32;
      5'd3:            p = 7'd21;
      5'd4:            p = 7'd16;
      5'd5:            p = 7'd12;
      5'd6:            p = 7'd10;
      5'd7:            p = 7'd9;
      5'd8:            p = 7'd8;
      5'd9:            p = 7'd7;
      5'd10:           p = 7'd6;
      5'd11, 5'd12:    p = 7'd5;
      [5'd13:5'd16]:   p = 7'd4;
      [5'd17:5'd21]:   p = 7'd3;
      [5'd22:5'd31]:   p = 7'd2;
      default:         p = '0;
    endcase
    return p;
  endfunction

  // floor(2^24 / per) + 1, exact quotient for any 12-bit index
  function automatic logic [RCP_W-1:0] recip_of(logic [WID_W-1:0] w);
    logic [RCP_W-1:0] r;
    r = '0;
    case (w) inside
      5'd1:            r = 24'd262145;
      5'd2:            r = 24'd524289;
      5'd3:            r = 24'd798916;
      5'd4:            r = 24'd1048577;
      5'd5:            r = 24'd1398102;
      5'd6:            r = 24'd1677722;
      5'd7:            r = 24'd1864136;
      5'd8:            r = 24'd2097153;
      5'd9:            r = 24'd2396746;
      5'd10:           r = 24'd2796203;
      5'd11, 5'd12:    r = 24'd3355444;
      [5'd13:5'd16]:   r = 24'd4194305;
      [5'd17:5'd21]:   r = 24'd5592406;
      [5'd22:5'd31]:   r = 24'd8388609;
      default:         r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [WORD_BITS-1:0] width_mask(logic [WID_W-1:0] w);
    return (64'(1) << w) - 64'(1);
  endfunction

  // number of significant bits of a value
  function automatic logic [WID_W-1:0] bit_len(logic [VAL_W-1:0] v);
    logic [WID_W-1:0] n;
    n = '0;
    for (int i = 0; i < VAL_W; i++) begin
      if (v[i]) n = WID_W'(i + 1);
    end
    return n;
  endfunction

endpackage

### hw/rtl/pfa_ram.sv
// ----------------------------------------------------------------------------
// pfa_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // registered read, holds until the next read
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

### hw/rtl/packed_field_array_autowiden.sv
// ----------------------------------------------------------------------------
// packed_field_array_autowiden
// Array of unsigned entries packed into 64-bit words at a common width,
// with automatic widening on write and explicit repack.
// ----------------------------------------------------------------------------
// One beat in gives one result beat; items are processed one at a time.
// After reset the word store is cleared by a pass over all MAX_ENTRIES/2
// words, during which no item is taken. Reads and writes go through the
// divide-by-reciprocal address path (three multiplies) and a registered
// memory read; a raw load writes its word directly. A repack (explicit, or
// a widening write) walks the store entry by entry, reading each source
// word once, then copies the repack buffer back into the word store in a
// sweep of the whole store, zeroing every word past the new contents.
// A widening write goes straight to the final width in one repack.
module packed_field_array_autowiden
  import pfa_pkg::*;
#(
  parameter int MAX_WIDTH   = 31
) (
  input  logic               clk,
  input  logic               rst_n,
  // item input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic [IDX_W-1:0]   in_index,
  input  logic [VAL_W-1:0]   in_value,
  input  logic [WID_W-1:0]   in_new_width,
  input  logic [63:0]        in_raw_word,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output logic [VAL_W-1:0]   out_read_value,
  output logic [WID_W-1:0]   out_width_now,
  output logic               out_widened,
  output logic               out_status,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CNT_W-1:0]   cfg_entry_count
);

  localparam int STORE_WORDS = MAX_ENTRIES / 2;
  localparam int AW          = $clog2(STORE_WORDS);
  localparam logic [AW:0] N_WORDS   = (AW+1)'(STORE_WORDS);
  localparam logic [AW:0] LAST_WORD = (AW+1)'(STORE_WORDS - 1);
  localparam logic [WID_W-1:0] MAX_W = WID_W'(MAX_WIDTH);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]     cfg_r;
  logic [CNT_W-1:0]     cnt;

  // latched item
  op_t                  op_r, op_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [VAL_W-1:0]     val_r, val_nxt;
  logic [WID_W-1:0]     nwi_r, nwi_nxt;
  logic [63:0]          raw_r, raw_nxt;

  logic [WID_W-1:0]     w_r, w_nxt;
  logic [WID_W-1:0]     rp_nw_r, rp_nw_nxt;

  // result in progress
  logic [VAL_W-1:0]     res_rd_r, res_rd_nxt;
  logic                 res_wid_r, res_wid_nxt;
  logic                 res_st_r, res_st_nxt;

  // address path
  logic [IDX_W-1:0]     q_r, q_nxt;
  logic [OFF_W-1:0]     rem_r, rem_nxt;
  logic [OFF_W-1:0]     off_r, off_nxt;

  // repack walk
  logic [CNT_W-1:0]     k_r, k_nxt;
  logic [AW-1:0]        sw_r, sw_nxt;
  logic [OFF_W-1:0]     soff_r, soff_nxt;
  logic [OFF_W-1:0]     scnt_r, scnt_nxt;
  logic [AW:0]          dw_r, dw_nxt;
  logic [OFF_W-1:0]     doff_r, doff_nxt;
  logic [OFF_W-1:0]     dcnt_r, dcnt_nxt;
  logic [63:0]          acc_r, acc_nxt;
  logic [AW:0]          ndw_r, ndw_nxt;

  // sweep counter and copy pipeline
  logic [AW:0]          ca_r, ca_nxt;
  logic                 pend_r, pend_nxt;
  logic [AW-1:0]        pa_r, pa_nxt;
  logic                 use_r, use_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]     out_rd_r, out_rd_nxt;
  logic [WID_W-1:0]     out_w_r, out_w_nxt;
  logic                 out_wid_r, out_wid_nxt;
  logic                 out_st_r, out_st_nxt;

  // memory ports
  logic                 ws_we, ws_re, rb_we, rb_re;
  logic [AW-1:0]        ws_waddr, ws_raddr, rb_waddr, rb_raddr;
  logic [63:0]          ws_wdata, ws_rdata, rb_wdata, rb_rdata;

  // decision helpers
  logic                 in_acc, out_free, idx_ok, load_ok;
  logic [WID_W-1:0]     bl, need_w, tgt_w, nw_cl;
  logic                 grow, nw_bad;
  logic                 last_k, src_full, dst_full, cp_end;
  logic [63:0]          src_ent, ins_ent, acc_w;
  logic [PER_W-1:0]     per_src, per_dst;

  pfa_ram #(.WIDTH(WORD_BITS), .DEPTH(STORE_WORDS)) u_word_store (
    .clk   (clk),
    .we    (ws_we),
    .waddr (ws_waddr),
    .wdata (ws_wdata),
    .re    (ws_re),
    .raddr (ws_raddr),
    .rdata (ws_rdata)
  );

  pfa_ram #(.WIDTH(WORD_BITS), .DEPTH(STORE_WORDS)) u_repack_buf (
    .clk   (clk),
    .we    (rb_we),
    .waddr (rb_waddr),
    .wdata (rb_wdata),
    .re    (rb_re),
    .raddr (rb_raddr),
    .rdata (rb_rdata)
  );

  // handshakes
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // entries held, clamped to capacity
  assign cnt = (32'(cfg_r) > 32'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : cfg_r;

  // range checks
  assign idx_ok  = CNT_W'(idx_r) < cnt;
  assign per_src = per_of(w_r);
  assign per_dst = per_of(rp_nw_r);
  assign load_ok = (32'(idx_r) * 32'(per_src) < 32'(cnt)) &&
                   (32'(idx_r) < 32'(STORE_WORDS));

  // width needed by a write value
  assign bl     = bit_len(val_r);
  assign need_w = (bl > w_r) ? bl : w_r;
  assign tgt_w  = (need_w > MAX_W) ? MAX_W : need_w;
  assign grow   = (tgt_w != w_r);

  // repack width clamp
  assign nw_bad = (nwi_r == '0) || (nwi_r > MAX_W);
  assign nw_cl  = (nwi_r == '0) ? WID_W'(1) : ((nwi_r > MAX_W) ? MAX_W : nwi_r);

  // walk step: extract from source word, insert into destination word
  assign src_ent  = (ws_rdata >> soff_r) & width_mask(w_r);
  assign ins_ent  = (src_ent & width_mask(rp_nw_r)) << doff_r;
  assign acc_w    = acc_r | ins_ent;
  assign last_k   = (k_r == cnt - CNT_W'(1));
  assign src_full = (scnt_r == OFF_W'(per_src - PER_W'(1)));
  assign dst_full = (dcnt_r == OFF_W'(per_dst - PER_W'(1)));
  assign cp_end   = (ca_r == N_WORDS) && !pend_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (ca_r == LAST_WORD) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_acc) state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        unique case (op_r)
          OP_READ:   state_nxt = idx_ok ? ST_ADR1 : ST_DONE;
          OP_WRITE: begin
            if (!idx_ok) state_nxt = ST_DONE;
            else if (grow) state_nxt = (cnt == '0) ? ST_CP : ST_RP_RD;
            else state_nxt = ST_ADR1;
          end
          OP_REPACK: state_nxt = (cnt == '0) ? ST_CP : ST_RP_RD;
          OP_LOAD:   state_nxt = ST_DONE;
          default:   state_nxt = ST_DONE;
        endcase
      end
      ST_RP_RD:  state_nxt = ST_RP_EXT;
      ST_RP_EXT: begin
        if (last_k) state_nxt = ST_CP;
        else if (src_full) state_nxt = ST_RP_RD;
      end
      ST_CP:     if (cp_end) state_nxt = (op_r == OP_WRITE) ? ST_ADR1 : ST_DONE;
      ST_ADR1:   state_nxt = ST_ADR2;
      ST_ADR2:   state_nxt = ST_ADR3;
      ST_ADR3:   state_nxt = ST_EXEC;
      ST_EXEC:   state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    op_nxt = op_r;  idx_nxt = idx_r;  val_nxt = val_r;
    nwi_nxt = nwi_r;  raw_nxt = raw_r;
    w_nxt = w_r;  rp_nw_nxt = rp_nw_r;
    res_rd_nxt = res_rd_r;  res_wid_nxt = res_wid_r;  res_st_nxt = res_st_r;
    q_nxt = q_r;  rem_nxt = rem_r;  off_nxt = off_r;
    k_nxt = k_r;  sw_nxt = sw_r;  soff_nxt = soff_r;  scnt_nxt = scnt_r;
    dw_nxt = dw_r;  doff_nxt = doff_r;  dcnt_nxt = dcnt_r;
    acc_nxt = acc_r;  ndw_nxt = ndw_r;
    ca_nxt = ca_r;  pend_nxt = pend_r;  pa_nxt = pa_r;  use_nxt = use_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_rd_nxt = out_rd_r;  out_w_nxt = out_w_r;
    out_wid_nxt = out_wid_r;  out_st_nxt = out_st_r;
    ws_we = 1'b0;  ws_waddr = '0;  ws_wdata = '0;
    ws_re = 1'b0;  ws_raddr = '0;
    rb_we = 1'b0;  rb_waddr = '0;  rb_wdata = '0;
    rb_re = 1'b0;  rb_raddr = '0;

    unique case (state_r)
      // zero the word store after reset
      ST_CLEAR: begin
        ws_we    = 1'b1;
        ws_waddr = AW'(ca_r);
        ca_nxt   = ca_r + (AW+1)'(1);
      end

      // take an item beat
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt      = op_t'(in_operation);
          idx_nxt     = in_index;
          val_nxt     = in_value;
          nwi_nxt     = in_new_width;
          raw_nxt     = in_raw_word;
          res_rd_nxt  = '0;
          res_wid_nxt = 1'b0;
          res_st_nxt  = 1'b0;
        end
      end

      // range checks, width decision, raw load
      ST_DECIDE: begin
        k_nxt = '0;  sw_nxt = '0;  soff_nxt = '0;  scnt_nxt = '0;
        dw_nxt = '0;  doff_nxt = '0;  dcnt_nxt = '0;  acc_nxt = '0;
        ndw_nxt = '0;  ca_nxt = '0;  pend_nxt = 1'b0;
        unique case (op_r)
          OP_READ:   res_st_nxt = !idx_ok;
          OP_WRITE: begin
            if (!idx_ok) begin
              res_st_nxt = 1'b1;
            end else begin
              res_st_nxt  = (bl > tgt_w);
              res_wid_nxt = grow;
              rp_nw_nxt   = tgt_w;
            end
          end
          OP_REPACK: begin
            res_st_nxt  = nw_bad;
            res_wid_nxt = 1'b1;
            rp_nw_nxt   = nw_cl;
          end
          OP_LOAD: begin
            if (load_ok) begin
              ws_we    = 1'b1;
              ws_waddr = AW'(idx_r);
              ws_wdata = raw_r;
            end else begin
              res_st_nxt = 1'b1;
            end
          end
          default: res_st_nxt = 1'b1;
        endcase
      end

      // fetch next source word
      ST_RP_RD: begin
        ws_re    = 1'b1;
        ws_raddr = sw_r;
      end

      // move one entry into the destination word
      ST_RP_EXT: begin
        if (dst_full || last_k) begin
          rb_we    = 1'b1;
          rb_waddr = AW'(dw_r);
          rb_wdata = acc_w;
          acc_nxt  = '0;
          dw_nxt   = dw_r + (AW+1)'(1);
          dcnt_nxt = '0;
          doff_nxt = '0;
        end else begin
          acc_nxt  = acc_w;
          dcnt_nxt = dcnt_r + OFF_W'(1);
          doff_nxt = OFF_W'(doff_r + OFF_W'(rp_nw_r));
        end
        if (last_k) begin
          ndw_nxt  = dw_r + (AW+1)'(1);
          ca_nxt   = '0;
          pend_nxt = 1'b0;
        end else begin
          k_nxt = k_r + CNT_W'(1);
          if (src_full) begin
            sw_nxt   = sw_r + AW'(1);
            scnt_nxt = '0;
            soff_nxt = '0;
          end else begin
            scnt_nxt = scnt_r + OFF_W'(1);
            soff_nxt = OFF_W'(soff_r + OFF_W'(w_r));
          end
        end
      end

      // copy buffer back, zero past the new contents
      ST_CP: begin
        if (ca_r != N_WORDS) begin
          rb_re    = 1'b1;
          rb_raddr = AW'(ca_r);
          pend_nxt = 1'b1;
          pa_nxt   = AW'(ca_r);
          use_nxt  = (ca_r < ndw_r);
          ca_nxt   = ca_r + (AW+1)'(1);
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          ws_we    = 1'b1;
          ws_waddr = pa_r;
          ws_wdata = use_r ? rb_rdata : '0;
        end
        if (cp_end) w_nxt = rp_nw_r;
      end

      // word index by reciprocal multiply
      ST_ADR1: begin
        q_nxt = IDX_W'((36'(idx_r) * 36'(recip_of(w_r))) >> RCP_W);
      end

      // slot within the word, fetch the word
      ST_ADR2: begin
        rem_nxt  = OFF_W'(idx_r - IDX_W'(q_r * IDX_W'(per_src)));
        ws_re    = 1'b1;
        ws_raddr = AW'(q_r);
      end

      // bit offset
      ST_ADR3: begin
        off_nxt = OFF_W'(11'(rem_r) * 11'(w_r));
      end

      // read out or modify and write back
      ST_EXEC: begin
        if (op_r == OP_READ) begin
          res_rd_nxt = VAL_W'((ws_rdata >> off_r) & width_mask(w_r));
        end else begin
          ws_we    = 1'b1;
          ws_waddr = AW'(q_r);
          ws_wdata = (ws_rdata & ~(width_mask(w_r) << off_r)) |
                     ((64'(val_r) & width_mask(w_r)) << off_r);
        end
      end

      // hand the result to the output register
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_rd_nxt    = res_rd_r;
          out_w_nxt     = w_r;
          out_wid_nxt   = res_wid_r;
          out_st_nxt    = res_st_r;
        end
      end

      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cfg_r       <= '0;
      w_r         <= RESET_WIDTH;
      ca_r        <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_valid && cfg_ready) cfg_r <= cfg_entry_count;
      w_r         <= w_nxt;
      ca_r        <= ca_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r <= op_nxt;  idx_r <= idx_nxt;  val_r <= val_nxt;
    nwi_r <= nwi_nxt;  raw_r <= raw_nxt;  rp_nw_r <= rp_nw_nxt;
    res_rd_r <= res_rd_nxt;  res_wid_r <= res_wid_nxt;  res_st_r <= res_st_nxt;
    q_r <= q_nxt;  rem_r <= rem_nxt;  off_r <= off_nxt;
    k_r <= k_nxt;  sw_r <= sw_nxt;  soff_r <= soff_nxt;  scnt_r <= scnt_nxt;
    dw_r <= dw_nxt;  doff_r <= doff_nxt;  dcnt_r <= dcnt_nxt;
    acc_r <= acc_nxt;  ndw_r <= ndw_nxt;
    pa_r <= pa_nxt;  use_r <= use_nxt;
    out_rd_r <= out_rd_nxt;  out_w_r <= out_w_nxt;
    out_wid_r <= out_wid_nxt;  out_st_r <= out_st_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_rd_r;
  assign out_width_now  = out_w_r;
  assign out_widened    = out_wid_r;
  assign out_status     = out_st_r;

  // checks
  `include "packed_field_array_autowiden_assert.svh"

  `PFA_ASSERT_ALWAYS(a_width_range, (w_r != '0) && (w_r <= MAX_W), "entry width out of range")
  `PFA_ASSERT_IMPL(a_dst_in_store, (state_r == ST_RP_EXT) && rb_we, dw_r < N_WORDS, "repack overruns the store")
  `PFA_ASSERT_IMPL(a_ndw_bound, state_r == ST_CP, ndw_r <= N_WORDS, "copy length beyond the store")
  `PFA_ASSERT_IMPL(a_rd_zero, (state_r == ST_DONE) && (op_r != OP_READ), res_rd_r == '0, "read value on a non-read")

endmodule

### sim/packed_field_array_autowiden_checker.sv
// ----------------------------------------------------------------------------
// packed_field_array_autowiden_checker
// Watches the item, result and configuration channels of the packed field
// array, keeps its own copy of the word store, width and entry count, works
// out the result of every accepted item and compares each result beat with
// the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
module packed_field_array_autowiden_checker
  import pfa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic [IDX_W-1:0]   in_index,
  input  logic [VAL_W-1:0]   in_value,
  input  logic [WID_W-1:0]   in_new_width,
  input  logic [63:0]        in_raw_word,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [VAL_W-1:0]   out_read_value,
  input  logic [WID_W-1:0]   out_width_now,
  input  logic               out_widened,
  input  logic               out_status,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CNT_W-1:0]   cfg_entry_count,
  output int                 fail_count,
  output int                 pending
);

  localparam int STORE_WORDS = 2048;
  localparam int ENTRY_LIMIT = 4096;
  localparam int WIDTH_LIMIT = 31;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic [WID_W-1:0] width_now;
    logic             widened;
    logic             status;
  } entry_result_t;

  logic [63:0]      packed_words [STORE_WORDS];
  logic [63:0]      scratch_words [STORE_WORDS];
  logic [WID_W-1:0] cur_width;
  logic [CNT_W-1:0] entry_count;
  entry_result_t    result_fifo [$];

  assign pending = result_fifo.size();

  function automatic int unsigned live_entries();
    return (entry_count > ENTRY_LIMIT) ? ENTRY_LIMIT : int'(entry_count);
  endfunction

  function automatic logic [63:0] low_mask(int unsigned w);
    return (64'd1 << w) - 64'd1;
  endfunction

  function automatic logic [63:0] fetch_entry(int unsigned k);
    int unsigned per;
    int unsigned word;
    int unsigned off;
    per  = 64 / cur_width;
    word = k / per;
    off  = (k % per) * cur_width;
    if (word >= STORE_WORDS) return 64'd0;
    return (packed_words[word] >> off) & low_mask(cur_width);
  endfunction

  task automatic store_entry(int unsigned k, logic [63:0] v);
    int unsigned per;
    int unsigned word;
    int unsigned off;
    logic [63:0] m;
    per  = 64 / cur_width;
    word = k / per;
    off  = (k % per) * cur_width;
    m    = low_mask(cur_width);
    if (word < STORE_WORDS)
      packed_words[word] = (packed_words[word] & ~(m << off)) | ((v & m) << off);
  endtask

  // rebuild the whole store at a new width, dropping bits above the mask
  task automatic repack_store(int unsigned nw);
    int unsigned cnt;
    int unsigned per;
    int unsigned word;
    int unsigned off;
    logic [63:0] m;
    cnt = live_entries();
    per = 64 / nw;
    m   = low_mask(nw);
    for (int i = 0; i < STORE_WORDS; i++) scratch_words[i] = 64'd0;
    for (int unsigned k = 0; k < cnt; k++) begin
      word = k / per;
      off  = (k % per) * nw;
      if (word < STORE_WORDS)
        scratch_words[word] = scratch_words[word] | ((fetch_entry(k) & m) << off);
    end
    for (int i = 0; i < STORE_WORDS; i++) packed_words[i] = scratch_words[i];
    cur_width = WID_W'(nw);
  endtask

  task automatic predict_item(op_t op, int unsigned idx, logic [63:0] val,
                              int unsigned nw, logic [63:0] raw);
    entry_result_t r;
    int unsigned   cnt;
    int unsigned   per;
    int unsigned   words;
    r   = '0;
    cnt = live_entries();
    case (op)
      OP_READ: begin
        if (idx < cnt) r.read_value = VAL_W'(fetch_entry(idx));
        else r.status = 1'b1;
      end
      OP_WRITE: begin
        if (idx >= cnt) begin
          r.status = 1'b1;
        end else begin
          while (val > low_mask(cur_width) && cur_width < WIDTH_LIMIT) begin
            repack_store(cur_width + 1);
            r.widened = 1'b1;
          end
          if (val > low_mask(cur_width)) r.status = 1'b1;
          store_entry(idx, val);
        end
      end
      OP_REPACK: begin
        if (nw == 0) begin
          nw = 1;
          r.status = 1'b1;
        end
        if (nw > WIDTH_LIMIT) begin
          nw = WIDTH_LIMIT;
          r.status = 1'b1;
        end
        repack_store(nw);
        r.widened = 1'b1;
      end
      default: begin
        per   = 64 / cur_width;
        words = (cnt + per - 1) / per;
        if (idx < words && idx < STORE_WORDS) packed_words[idx] = raw;
        else r.status = 1'b1;
      end
    endcase
    r.width_now = cur_width;
    result_fifo.push_back(r);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // track config, predict on input beats, compare on result beats
  always @(posedge clk) begin
    entry_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < STORE_WORDS; i++) packed_words[i] = 64'd0;
      cur_width   = RESET_WIDTH;
      entry_count = '0;
      result_fifo.delete();
      fail_count  = 0;
    end else begin
      if (cfg_valid && cfg_ready) entry_count = cfg_entry_count;
      if (in_valid && !in_stall)
        predict_item(op_t'(in_operation), in_index, 64'(in_value), in_new_width,
                     in_raw_word);
      if (out_valid && !out_stall) begin
        if (result_fifo.size() == 0) begin
          report_mismatch("result beat with nothing outstanding", 64'd0, 64'd0);
        end else begin
          want = result_fifo.pop_front();
          if (out_read_value !== want.read_value)
            report_mismatch("read_value", 64'(out_read_value), 64'(want.read_value));
          if (out_width_now !== want.width_now)
            report_mismatch("width_now", 64'(out_width_now), 64'(want.width_now));
          if (out_widened !== want.widened)
            report_mismatch("widened", 64'(out_widened), 64'(want.widened));
          if (out_status !== want.status)
            report_mismatch("status", 64'(out_status), 64'(want.status));
        end
      end
    end
  end

endmodule

### sim/packed_field_array_autowiden_tb.sv
// ----------------------------------------------------------------------------
// packed_field_array_autowiden_tb
// Drives reads, writes, repacks and raw word loads into the packed field
// array over a range of entry counts, with random gaps and back-pressure,
// and lets the checker compare every result beat against its prediction.
// ----------------------------------------------------------------------------
module packed_field_array_autowiden_tb;
  import pfa_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [1:0]       in_operation;
  logic [IDX_W-1:0] in_index;
  logic [VAL_W-1:0] in_value;
  logic [WID_W-1:0] in_new_width;
  logic [63:0]      in_raw_word;
  logic             out_valid;
  logic             out_stall;
  logic [VAL_W-1:0] out_read_value;
  logic [WID_W-1:0] out_width_now;
  logic             out_widened;
  logic             out_status;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_entry_count;

  int fail_count;
  int pending;
  int send_idle;
  int recv_idle;
  int items_sent;
  int watchdog;
  int live_count;
  int repacks_sent;
  logic [WID_W-1:0] seen_width;

  packed_field_array_autowiden i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_index        (in_index),
    .in_value        (in_value),
    .in_new_width    (in_new_width),
    .in_raw_word     (in_raw_word),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_value  (out_read_value),
    .out_width_now   (out_width_now),
    .out_widened     (out_widened),
    .out_status      (out_status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_entry_count (cfg_entry_count)
  );

  packed_field_array_autowiden_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_index        (in_index),
    .in_value        (in_value),
    .in_new_width    (in_new_width),
    .in_raw_word     (in_raw_word),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_value  (out_read_value),
    .out_width_now   (out_width_now),
    .out_widened     (out_widened),
    .out_status      (out_status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_entry_count (cfg_entry_count),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // random receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  // current width as reported by the block, used only to shape stimulus
  always @(posedge clk) begin
    if (out_valid && !out_stall) seen_width <= out_width_now;
  end

  // watchdog: cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      watchdog <= 0;
    else
      watchdog <= watchdog + 1;
    if (watchdog >= WATCHDOG_LIMIT) begin
      $display("Timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_item(op_t op, int unsigned idx, logic [VAL_W-1:0] val,
                           logic [WID_W-1:0] nw, logic [63:0] raw);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_index     <= IDX_W'(idx);
    in_value     <= val;
    in_new_width <= nw;
    in_raw_word  <= raw;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
    items_sent++;
    if (op == OP_REPACK) repacks_sent++;
  endtask

  // drain outstanding results, then write the entry count
  task automatic set_entry_count(int unsigned cnt);
    in_valid <= 1'b0;
    @(posedge clk);
    forever begin
      @(negedge clk);
      if (pending == 0) break;
    end
    @(posedge clk);
    cfg_valid       <= 1'b1;
    cfg_entry_count <= CNT_W'(cnt);
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
    cfg_valid  <= 1'b0;
    live_count = (cnt > 4096) ? 4096 : cnt;
  endtask

  // one random item; at large counts repacks and widening are avoided
  task automatic send_random(bit big);
    op_t         op;
    int unsigned idx;
    int unsigned per;
    int unsigned words;
    int unsigned len;
    logic [VAL_W-1:0] val;
    op  = op_t'($urandom_range(3));
    if (big && op == OP_REPACK) op = OP_READ;
    per   = 64 / ((seen_width == 0) ? 1 : seen_width);
    words = (live_count + per - 1) / per;
    idx   = $urandom_range(4095);
    if ($urandom_range(99) < 85) begin
      if (op == OP_LOAD && words > 0) idx = $urandom_range(words - 1);
      else if (op != OP_LOAD && live_count > 0) idx = $urandom_range(live_count - 1);
    end
    if (big) begin
      val = VAL_W'($urandom) & VAL_W'((64'd1 << seen_width) - 64'd1);
    end else begin
      len = ($urandom_range(99) < 70) ? $urandom_range(seen_width) : $urandom_range(31);
      val = VAL_W'($urandom) & VAL_W'((64'd1 << len) - 64'd1);
    end
    send_item(op, idx, val, WID_W'($urandom_range(31)), {$urandom, $urandom});
  endtask

  initial begin
    int unsigned counts [7];
    int unsigned sizes [7];
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_operation    = OP_READ;
    in_index        = '0;
    in_value        = '0;
    in_new_width    = '0;
    in_raw_word     = '0;
    out_stall       = 1'b0;
    cfg_valid       = 1'b0;
    cfg_entry_count = '0;
    send_idle       = 0;
    recv_idle       = 0;
    items_sent      = 0;
    repacks_sent    = 0;
    watchdog        = 0;
    live_count      = 0;
    seen_width      = RESET_WIDTH;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // empty array: everything out of range, repack of nothing
    set_entry_count(0);
    send_item(OP_READ, 0, '0, 5'd4, 64'd0);
    send_item(OP_WRITE, 0, 31'd1, 5'd4, 64'd0);
    send_item(OP_LOAD, 0, '0, 5'd4, '1);
    send_item(OP_REPACK, 0, '0, 5'd4, 64'd0);

    // directed cases on a small array
    set_entry_count(20);
    send_item(OP_WRITE, 19, 31'd15, 5'd4, 64'd0);
    send_item(OP_READ, 19, '0, 5'd4, 64'd0);
    send_item(OP_READ, 20, '0, 5'd4, 64'd0);
    send_item(OP_READ, 4095, '0, 5'd4, 64'd0);
    send_item(OP_WRITE, 0, 31'd16, 5'd4, 64'd0);
    send_item(OP_WRITE, 5, 31'h7FFF_FFFF, 5'd4, 64'd0);
    send_item(OP_READ, 5, '0, 5'd4, 64'd0);
    send_item(OP_READ, 0, '0, 5'd4, 64'd0);
    send_item(OP_WRITE, 4095, 31'd3, 5'd4, 64'd0);
    send_item(OP_REPACK, 0, '0, 5'd0, 64'd0);
    send_item(OP_READ, 19, '0, 5'd4, 64'd0);
    send_item(OP_REPACK, 0, '0, 5'd31, 64'd0);
    send_item(OP_REPACK, 0, '0, 5'd31, 64'd0);
    send_item(OP_LOAD, 0, '0, 5'd4, '1);
    send_item(OP_LOAD, 9, '0, 5'd4, 64'hA5A5_5A5A_0F0F_F0F0);
    send_item(OP_LOAD, 10, '0, 5'd4, '1);
    send_item(OP_LOAD, 4095, '0, 5'd4, '1);
    send_item(OP_READ, 1, '0, 5'd4, 64'd0);
    send_item(OP_REPACK, 0, '0, 5'd3, 64'd0);
    send_item(OP_READ, 1, '0, 5'd4, 64'd0);
    send_item(OP_WRITE, 2, 31'h4000_0000, 5'd4, 64'd0);

    // random phases over several entry counts and idle patterns
    counts = '{1, 37, 120, 4096, 8191, 63, 5};
    sizes  = '{150, 350, 150, 250, 150, 300, 150};
    foreach (counts[p]) begin
      set_entry_count(counts[p]);
      for (int i = 0; i < sizes[p]; i++) begin
        if (items_sent < 520) begin
          send_idle = 22;
          recv_idle = 46;
        end else if (items_sent < 1030) begin
          send_idle = 46;
          recv_idle = 22;
        end else begin
          send_idle = 0;
          recv_idle = 0;
        end
        send_random(counts[p] >= 4096);
      end
    end

    // wait for the last results to drain
    in_valid <= 1'b0;
    forever begin
      @(negedge clk);
      if (pending == 0) break;
    end
    repeat (50) @(posedge clk);

    $display("Covered %0d items (%0d repacks) over entry counts 0 to 8191,", items_sent,
             repacks_sent);
    $display("with sender gaps and receiver back-pressure in both ratios and none.");
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
